@@ hdl/vfa_pkg.sv @@
package vfa_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COMP_W  = 32;
    localparam int OPND_W  = COMP_W + 1;
    localparam int ADD_W   = COMP_W + 2;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MERGE_W = SUM_W + 2;
    localparam int LANES   = 4;

    typedef enum logic [2:0] {
        OP_SUM    = 3'd0,
        OP_SUB    = 3'd1,
        OP_SCALE  = 3'd2,
        OP_DOT    = 3'd3,
        OP_CROSS3 = 3'd4,
        OP_CROSS4 = 3'd5,
        OP_LERP   = 3'd6,
        OP_CLERP  = 3'd7
    } t_op;

    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [ADD_W-1:0]  t_addend;
    typedef logic signed [SUM_W-1:0]  t_lane_sum;

    typedef struct packed {
        logic dot;
        logic oor;
    } t_ctl;

endpackage

@@ hdl/vfa_lane.sv @@
module vfa_lane #(
    parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_sum,
    input  vfa_pkg::t_opnd     i_a0,
    input  vfa_pkg::t_opnd     i_b0,
    input  vfa_pkg::t_opnd     i_a1,
    input  vfa_pkg::t_opnd     i_b1,
    input  vfa_pkg::t_addend   i_add,
    output vfa_pkg::t_lane_sum o_sum
);

    logic signed [vfa_pkg::PROD_W-1:0] n_p0, n_p1, r_p0, r_p1;
    logic signed [vfa_pkg::PROD_W-1:0] w_t0, w_t1;
    vfa_pkg::t_addend                  r_add;
    vfa_pkg::t_lane_sum                n_sum, r_sum;

    assign n_p0 = vfa_pkg::PROD_W'(i_a0) * vfa_pkg::PROD_W'(i_b0);
    assign n_p1 = vfa_pkg::PROD_W'(i_a1) * vfa_pkg::PROD_W'(i_b1);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_add <= i_add;
        end
    end

    // floor division by the fraction scale
    assign w_t0  = r_p0 >>> FRAC_BITS;
    assign w_t1  = r_p1 >>> FRAC_BITS;
    assign n_sum = vfa_pkg::SUM_W'(r_add) + vfa_pkg::SUM_W'(w_t0) - vfa_pkg::SUM_W'(w_t1);

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

@@ hdl/vfa_merge.sv @@
module vfa_merge (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  vfa_pkg::t_ctl               i_ctl,
    input  vfa_pkg::t_lane_sum          i_sum [vfa_pkg::LANES],
    output logic [vfa_pkg::COMP_W-1:0]  o_res [vfa_pkg::LANES],
    output logic                        o_oor,
    output logic                        o_ovf
);

    localparam logic signed [vfa_pkg::MERGE_W-1:0] MAX_V =
        vfa_pkg::MERGE_W'(64'sd2147483647);
    localparam logic signed [vfa_pkg::MERGE_W-1:0] MIN_V =
        vfa_pkg::MERGE_W'(-64'sd2147483648);

    logic signed [vfa_pkg::MERGE_W-1:0] w_wide [vfa_pkg::LANES];
    logic [vfa_pkg::COMP_W-1:0]         n_res  [vfa_pkg::LANES];
    logic [vfa_pkg::COMP_W-1:0]         r_res  [vfa_pkg::LANES];
    logic [vfa_pkg::LANES-1:0]          w_sat;
    logic                               n_ovf;
    logic                               r_oor, r_ovf;

    always_comb begin
        if (i_ctl.dot) begin
            w_wide[0] = vfa_pkg::MERGE_W'(i_sum[0]) + vfa_pkg::MERGE_W'(i_sum[1])
                      + vfa_pkg::MERGE_W'(i_sum[2]) + vfa_pkg::MERGE_W'(i_sum[3]);
            for (int i = 1; i < vfa_pkg::LANES; i++) begin
                w_wide[i] = '0;
            end
        end else begin
            for (int i = 0; i < vfa_pkg::LANES; i++) begin
                w_wide[i] = vfa_pkg::MERGE_W'(i_sum[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < vfa_pkg::LANES; i++) begin
            if (w_wide[i] > MAX_V) begin
                n_res[i] = MAX_V[vfa_pkg::COMP_W-1:0];
                w_sat[i] = 1'b1;
            end else if (w_wide[i] < MIN_V) begin
                n_res[i] = MIN_V[vfa_pkg::COMP_W-1:0];
                w_sat[i] = 1'b1;
            end else begin
                n_res[i] = w_wide[i][vfa_pkg::COMP_W-1:0];
                w_sat[i] = 1'b0;
            end
        end
        n_ovf = |w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_oor <= i_ctl.oor;
            r_ovf <= n_ovf;
        end
    end

    assign o_res = r_res;
    assign o_oor = r_oor;
    assign o_ovf = r_ovf;

endmodule

@@ hdl/vec4_fixed_alu_core.sv @@
// channel   dir  tdata                                tuser
// s_axis    in   v_x v_y v_z v_w u_x u_y u_z u_w t   opcode
// m_axis    out  result_x result_y result_z result_w factor_out_of_range overflow
//
// one request per cycle while the output is not stalled; stages in order:
// operand select, lane multipliers, lane sums, merge and saturate
// each stage moves up when the next is empty or moving, so bubbles close up
// reset clears the stage valid bits only
module vec4_fixed_alu_core #(
    parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // v_x, v_y, v_z, v_w, u_x, u_y, u_z, u_w, factor
    input  logic [287:0] s_axis_tdata,
    // opcode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_x, result_y, result_z, result_w
    output logic [127:0] m_axis_tdata,
    // factor_out_of_range, overflow
    output logic [1:0]   m_axis_tuser
);

    localparam int CW = vfa_pkg::COMP_W;
    localparam int NL = vfa_pkg::LANES;
    localparam vfa_pkg::t_opnd ONE = vfa_pkg::OPND_W'(1) <<< FRAC_BITS;

    logic signed [CW-1:0] w_v [NL];
    logic signed [CW-1:0] w_u [NL];
    logic signed [CW-1:0] w_t;
    vfa_pkg::t_op         w_op;

    vfa_pkg::t_opnd   n_a0 [NL], n_b0 [NL], n_a1 [NL], n_b1 [NL];
    vfa_pkg::t_opnd   r_a0 [NL], r_b0 [NL], r_a1 [NL], r_b1 [NL];
    vfa_pkg::t_addend n_add [NL], r_add [NL];
    vfa_pkg::t_opnd   w_tsel, w_diff [NL];
    vfa_pkg::t_ctl    n_ctl, r_ctl1, r_ctl2, r_ctl3;
    vfa_pkg::t_lane_sum w_sum [NL];
    logic [CW-1:0]    w_res [NL];

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;
    logic w_oor, w_oor_flag;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_v[i] = s_axis_tdata[CW*i +: CW];
            w_u[i] = s_axis_tdata[CW*(NL+i) +: CW];
        end
        w_t  = s_axis_tdata[CW*2*NL +: CW];
        w_op = vfa_pkg::t_op'(s_axis_tuser);
    end

    assign w_oor = (w_t < 0) || (vfa_pkg::OPND_W'(w_t) > ONE);

    always_comb begin
        w_tsel = vfa_pkg::OPND_W'(w_t);
        if (w_oor && (w_op == vfa_pkg::OP_CLERP)) begin
            w_tsel = (w_t < 0) ? '0 : ONE;
        end
        for (int i = 0; i < NL; i++) begin
            w_diff[i] = vfa_pkg::OPND_W'(w_u[i]) - vfa_pkg::OPND_W'(w_v[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_a0[i]  = '0;
            n_b0[i]  = '0;
            n_a1[i]  = '0;
            n_b1[i]  = '0;
            n_add[i] = '0;
        end
        w_oor_flag = 1'b0;
        unique case (w_op)
            vfa_pkg::OP_SUM: begin
                for (int i = 0; i < NL; i++) begin
                    n_add[i] = vfa_pkg::ADD_W'(w_v[i]) + vfa_pkg::ADD_W'(w_u[i]);
                end
            end
            vfa_pkg::OP_SUB: begin
                for (int i = 0; i < NL; i++) begin
                    n_add[i] = vfa_pkg::ADD_W'(w_v[i]) - vfa_pkg::ADD_W'(w_u[i]);
                end
            end
            vfa_pkg::OP_SCALE: begin
                for (int i = 0; i < NL; i++) begin
                    n_a0[i] = vfa_pkg::OPND_W'(w_v[i]);
                    n_b0[i] = vfa_pkg::OPND_W'(w_t);
                end
            end
            vfa_pkg::OP_DOT: begin
                for (int i = 0; i < NL; i++) begin
                    n_a0[i] = vfa_pkg::OPND_W'(w_v[i]);
                    n_b0[i] = vfa_pkg::OPND_W'(w_u[i]);
                end
            end
            vfa_pkg::OP_CROSS3: begin
                n_a0[0] = vfa_pkg::OPND_W'(w_v[1]); n_b0[0] = vfa_pkg::OPND_W'(w_u[2]);
                n_a1[0] = vfa_pkg::OPND_W'(w_v[2]); n_b1[0] = vfa_pkg::OPND_W'(w_u[1]);
                n_a0[1] = vfa_pkg::OPND_W'(w_v[2]); n_b0[1] = vfa_pkg::OPND_W'(w_u[0]);
                n_a1[1] = vfa_pkg::OPND_W'(w_v[0]); n_b1[1] = vfa_pkg::OPND_W'(w_u[2]);
                n_a0[2] = vfa_pkg::OPND_W'(w_v[0]); n_b0[2] = vfa_pkg::OPND_W'(w_u[1]);
                n_a1[2] = vfa_pkg::OPND_W'(w_v[1]); n_b1[2] = vfa_pkg::OPND_W'(w_u[0]);
            end
            vfa_pkg::OP_CROSS4: begin
                n_a0[0] = vfa_pkg::OPND_W'(w_v[0]); n_b0[0] = vfa_pkg::OPND_W'(w_u[1]);
                n_a1[0] = vfa_pkg::OPND_W'(w_v[1]); n_b1[0] = vfa_pkg::OPND_W'(w_u[0]);
                n_a0[1] = vfa_pkg::OPND_W'(w_v[0]); n_b0[1] = vfa_pkg::OPND_W'(w_u[2]);
                n_a1[1] = vfa_pkg::OPND_W'(w_v[2]); n_b1[1] = vfa_pkg::OPND_W'(w_u[0]);
                n_a0[2] = vfa_pkg::OPND_W'(w_v[0]); n_b0[2] = vfa_pkg::OPND_W'(w_u[3]);
                n_a1[2] = vfa_pkg::OPND_W'(w_v[3]); n_b1[2] = vfa_pkg::OPND_W'(w_u[0]);
                n_a0[3] = vfa_pkg::OPND_W'(w_v[1]); n_b0[3] = vfa_pkg::OPND_W'(w_u[2]);
                n_a1[3] = vfa_pkg::OPND_W'(w_v[2]); n_b1[3] = vfa_pkg::OPND_W'(w_u[1]);
            end
            vfa_pkg::OP_LERP, vfa_pkg::OP_CLERP: begin
                w_oor_flag = w_oor;
                for (int i = 0; i < NL; i++) begin
                    n_a0[i]  = w_tsel;
                    n_b0[i]  = w_diff[i];
                    n_add[i] = vfa_pkg::ADD_W'(w_v[i]);
                end
            end
            default: begin
            end
        endcase
        n_ctl.dot = (w_op == vfa_pkg::OP_DOT);
        n_ctl.oor = w_oor_flag;
    end

    assign w_en4 = !r_v4 || m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_a0   <= n_a0;
            r_b0   <= n_b0;
            r_a1   <= n_a1;
            r_b1   <= n_b1;
            r_add  <= n_add;
            r_ctl1 <= n_ctl;
        end
        if (w_en2) r_ctl2 <= r_ctl1;
        if (w_en3) r_ctl3 <= r_ctl2;
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        vfa_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en_mul (w_en2),
            .i_en_sum (w_en3),
            .i_a0     (r_a0[g]),
            .i_b0     (r_b0[g]),
            .i_a1     (r_a1[g]),
            .i_b1     (r_b1[g]),
            .i_add    (r_add[g]),
            .o_sum    (w_sum[g])
        );
    end

    vfa_merge u_merge (
        .i_clk (i_clk),
        .i_en  (w_en4),
        .i_ctl (r_ctl3),
        .i_sum (w_sum),
        .o_res (w_res),
        .o_oor (m_axis_tuser[0]),
        .o_ovf (m_axis_tuser[1])
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {w_res[3], w_res[2], w_res[1], w_res[0]};

endmodule
